// ----- hdl/rpd_pkg.sv -----
// Package for the receive packet deframer: types, codes, constants and the CRC-16 byte update.
// No dependencies.
package rpd_pkg;

    localparam int MaxPayload = 64;
    localparam logic [7:0] LenMin = 8'd4;
    localparam logic [7:0] LenMax = 8'(MaxPayload + 3);
    localparam logic [15:0] CrcPoly = 16'h8005;
    localparam logic [15:0] CrcInit = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_LEN  = 4'b0001,
        PH_DST  = 4'b0010,
        PH_SRC  = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        K_SRC     = 2'd0,
        K_PAYLOAD = 2'd1,
        K_GOOD    = 2'd2,
        K_BAD     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_value;
        logic [7:0] byte_index;
        logic       last;
    } result_t;

    // MSB-first CRC-16 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        logic        top;
        c = crc_in;
        for (int i = 7; i >= 0; i--) begin
            top = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (top)
                c = c ^ CrcPoly;
        end
        return c;
    endfunction

endpackage

// ----- hdl/rx_packet_deframer_crc16_top.sv -----
// Receive packet deframer with CRC-16 (poly 0x8005, init 0xFFFF) check, top level.
// Depends on rpd_pkg.
//
// Takes one received byte per transaction at full rate while the skid register is empty: a
// new byte can then be accepted in every cycle, and each byte's frame state and CRC
// update is done in the cycle it is accepted. Results (source address, payload bytes,
// frame good/bad status) leave through an output register backed by a one-entry skid
// register, so input keeps flowing while a result waits; input stalls only when both are
// full. tuser on the input is abort: it drops any open frame (reporting frame bad if the
// source was already reported) and returns to waiting for a length byte. node_address
// may be written only while the block is idle.
module rx_packet_deframer_crc16_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] abort
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_value, [15:8] byte_index
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last
);
    import rpd_pkg::*;

    logic [7:0]  node_address_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  plen_reg, plen_next;
    logic [7:0]  pos_reg, pos_next;

    result_t     res;
    logic        res_valid;
    result_t     out_reg;
    logic        out_valid_reg;
    result_t     skid_reg;
    logic        skid_valid_reg;

    logic        in_acc;
    logic        out_take;
    logic [15:0] crc_upd;
    logic [7:0]  rx_byte;
    logic        abort;

    assign rx_byte       = s_axis_tdata;
    assign abort         = s_axis_tuser;
    assign s_axis_tready = !skid_valid_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_take      = out_valid_reg && m_axis_tready;
    assign crc_upd       = crc_byte((phase_reg == PH_DST || phase_reg == PH_SRC ||
                                     phase_reg == PH_DATA) ? crc_reg : CrcInit, rx_byte);

    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        plen_next  = plen_reg;
        pos_next   = pos_reg;
        res_valid  = 1'b0;
        res        = '{kind: K_BAD, data_value: 8'd0, byte_index: 8'd0, last: 1'b1};
        if (in_acc)
        begin
            if (abort)
            begin
                res_valid  = (phase_reg == PH_DATA);
                phase_next = PH_LEN;
                crc_next   = CrcInit;
                plen_next  = 8'd0;
                pos_next   = 8'd0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_DST:
                    begin
                        if (rx_byte == 8'd0 || rx_byte == node_address_reg)
                        begin
                            crc_next   = crc_upd;
                            phase_next = PH_SRC;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                            crc_next   = CrcInit;
                            plen_next  = 8'd0;
                            pos_next   = 8'd0;
                        end
                    end
                    PH_SRC:
                    begin
                        crc_next   = crc_upd;
                        pos_next   = 8'd0;
                        phase_next = PH_DATA;
                        res_valid  = 1'b1;
                        res        = '{kind: K_SRC, data_value: rx_byte, byte_index: 8'd0,
                                       last: 1'b0};
                    end
                    PH_DATA:
                    begin
                        if (pos_reg < plen_reg)
                        begin
                            crc_next  = crc_upd;
                            pos_next  = pos_reg + 8'd1;
                            res_valid = 1'b1;
                            res       = '{kind: K_PAYLOAD, data_value: rx_byte,
                                          byte_index: pos_reg, last: 1'b0};
                        end
                        else if (pos_reg == plen_reg && rx_byte == crc_reg[15:8])
                        begin
                            pos_next = pos_reg + 8'd1;
                        end
                        else
                        begin
                            // high CRC byte mismatch, or low CRC byte check
                            res_valid  = 1'b1;
                            if (pos_reg != plen_reg && rx_byte == crc_reg[7:0])
                                res.kind = K_GOOD;
                            phase_next = PH_LEN;
                            crc_next   = CrcInit;
                            plen_next  = 8'd0;
                            pos_next   = 8'd0;
                        end
                    end
                    default:
                    begin
                        if (rx_byte < LenMin || rx_byte > LenMax)
                        begin
                            phase_next = PH_LEN;
                            crc_next   = CrcInit;
                            plen_next  = 8'd0;
                            pos_next   = 8'd0;
                        end
                        else
                        begin
                            crc_next   = crc_upd;
                            plen_next  = rx_byte - 8'd2;
                            pos_next   = 8'd0;
                            phase_next = PH_DST;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= 8'd0;
            phase_reg        <= PH_LEN;
            crc_reg          <= CrcInit;
            plen_reg         <= 8'd0;
            pos_reg          <= 8'd0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                node_address_reg <= cfg_wdata;
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            plen_reg  <= plen_next;
            pos_reg   <= pos_next;
            if (skid_valid_reg)
            begin
                if (out_take)
                    skid_valid_reg <= 1'b0;
            end
            else if (res_valid)
            begin
                if (out_valid_reg && !out_take)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_take)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.byte_index, out_reg.data_value};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last) |-> (out_reg.kind == K_GOOD || out_reg.kind == K_BAD))
        else $error("last flag on a non-status result");

    a_idle_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEN) |-> (crc_reg == CrcInit && pos_reg == 8'd0))
        else $error("stale CRC or position while waiting for length");

    a_abort_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && abort) |=> (phase_reg == PH_LEN))
        else $error("abort did not restart the deframer");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (pos_reg <= plen_reg + 8'd1))
        else $error("position past the CRC bytes");

endmodule
